@@ src/bbpt_pkg.sv @@
package bbpt_pkg;

    // Command codes carried by an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // Grid and fixed-point constants.
    localparam int MAX_LEVEL  = 64;
    localparam int LEVEL_W    = 7;
    localparam int CELL_W     = 6;
    localparam int COORD_W    = 32;
    localparam int SLOT_W     = 4;
    localparam int PARAM_W    = 17;
    localparam int DIVIDEND_W = LEVEL_W + 16;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(4);
    localparam logic [PARAM_W-1:0] Q16_ONE     = PARAM_W'(65536);

    // One queued word after classification.
    typedef struct packed {
        logic                       command;
        logic [SLOT_W-1:0]          point_slot;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic [LEVEL_W-1:0]         level;
        logic [LEVEL_W-1:0]         cell_u;
        logic [LEVEL_W-1:0]         cell_v;
    } bbpt_item_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } bbpt_qstat_t;

    // Corner offsets of the six vertices of a cell.
    function automatic logic corner_du(input logic [2:0] k);
        logic r;
        case (k)
            3'd1, 3'd4, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic corner_dv(input logic [2:0] k);
        logic r;
        case (k)
            3'd2, 3'd3, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ src/bbpt_front.sv @@
module bbpt_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbpt_pkg::LEVEL_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [bbpt_pkg::SLOT_W-1:0]      point_slot,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_x,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_y,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_z,
    input  logic [bbpt_pkg::CELL_W-1:0]      cell_u,
    input  logic [bbpt_pkg::CELL_W-1:0]      cell_v,
    input  bbpt_pkg::bbpt_qstat_t            qstat,
    output logic                             push,
    output bbpt_pkg::bbpt_item_t             push_item
);
    import bbpt_pkg::*;

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_eff;
    logic [LEVEL_W-1:0] cu_ext;
    logic [LEVEL_W-1:0] cv_ext;

    // Level register; always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_valid)
        begin
            level_reg <= cfg_data;
        end
    end

    // Clamp the level into 1..MAX_LEVEL and the cell below it.
    always_comb
    begin
        if (level_reg == '0)
            level_eff = LEVEL_W'(1);
        else if (level_reg > LEVEL_W'(MAX_LEVEL))
            level_eff = LEVEL_W'(MAX_LEVEL);
        else
            level_eff = level_reg;
        cu_ext = LEVEL_W'(cell_u);
        cv_ext = LEVEL_W'(cell_v);
        if (cu_ext >= level_eff)
            cu_ext = level_eff - LEVEL_W'(1);
        if (cv_ext >= level_eff)
            cv_ext = level_eff - LEVEL_W'(1);
    end

    // Hand the classified word to the queue.
    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;

    always_comb
    begin
        push_item.command    = command;
        push_item.point_slot = point_slot;
        push_item.point_x    = point_x;
        push_item.point_y    = point_y;
        push_item.point_z    = point_z;
        push_item.level      = level_eff;
        push_item.cell_u     = cu_ext;
        push_item.cell_v     = cv_ext;
    end

endmodule

@@ src/bbpt_queue.sv @@
module bbpt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bbpt_pkg::bbpt_item_t  push_item,
    input  logic                  pop,
    output bbpt_pkg::bbpt_item_t  head_item,
    output bbpt_pkg::bbpt_qstat_t qstat
);
    import bbpt_pkg::*;

    bbpt_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign head_item   = slot_reg[rd_ptr_reg];

    // Two-entry word queue between front and back.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ src/bbpt_back.sv @@
module bbpt_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bbpt_pkg::bbpt_item_t             head_item,
    input  bbpt_pkg::bbpt_qstat_t            qstat,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_x,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_y,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_z,
    output logic [2:0]                       vert_index,
    output logic                             last_vertex
);
    import bbpt_pkg::*;

    localparam int OPND_W = 36;
    localparam int PROD_W = OPND_W + PARAM_W + 1;
    localparam int ROW_W  = 52;
    localparam int COL_W  = 56;
    localparam int MA_W   = 34;
    localparam int MB_W   = 19;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_WGT, S_RD, S_MUL, S_ACC, S_OUT
    } state_t;

    state_t state_reg;

    // Control point store, one array per coordinate.
    logic signed [COORD_W-1:0] mem [3][16];
    logic signed [COORD_W-1:0] p_reg [3];

    logic [LEVEL_W-1:0]    level_reg;
    logic [DIVIDEND_W-1:0] dvd_reg [4];
    logic [LEVEL_W:0]      rem_reg [4];
    logic [DIVIDEND_W-1:0] quo_reg [4];
    logic [4:0]            div_cnt_reg;
    logic [1:0]            wp_reg;
    logic [2:0]            ws_reg;
    logic [MA_W-1:0]       uu_reg;
    logic [MA_W-1:0]       ww_reg;
    logic [PARAM_W-1:0]    wgt_reg [4][4];
    logic [2:0]            vk_reg;
    logic [1:0]            ri_reg;
    logic [2:0]            cj_reg;
    logic [PARAM_W-1:0]    w_reg;
    logic signed [OPND_W-1:0] rnd_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [ROW_W-1:0]  row_acc_reg [3];
    logic signed [COL_W-1:0]  col_acc_reg [3];

    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic [PARAM_W-1:0]    cur_u;
    logic [PARAM_W-1:0]    cur_w;
    logic [MA_W-1:0]       ma;
    logic [MB_W-1:0]       mb;
    logic [MA_W+MB_W-1:0]  mprod;
    logic                  du;
    logic                  dv;
    logic signed [COL_W-1:0] fin [3];
    logic signed [COORD_W-1:0] sat [3];
    logic                  out_free;

    assign pop      = (state_reg == S_IDLE) && !qstat.empty;
    assign rd_en    = (state_reg == S_RD) && !cj_reg[2];
    assign rd_addr  = {ri_reg, cj_reg[1:0]};
    assign du       = corner_du(vk_reg);
    assign dv       = corner_dv(vk_reg);
    assign out_free = !out_valid || !out_stall;

    // Point store write on a load word, registered read for the MAC lanes.
    always_ff @(posedge clk)
    begin
        if (pop && head_item.command == CMD_LOAD)
        begin
            mem[0][head_item.point_slot] <= head_item.point_x;
            mem[1][head_item.point_slot] <= head_item.point_y;
            mem[2][head_item.point_slot] <= head_item.point_z;
        end
        if (rd_en)
        begin
            for (int l = 0; l < 3; l++)
                p_reg[l] <= mem[l][rd_addr];
        end
    end

    // Shared weight multiplier operands.
    always_comb
    begin
        cur_u = quo_reg[wp_reg][PARAM_W-1:0];
        cur_w = Q16_ONE - cur_u;
        case (ws_reg)
            3'd0:    begin ma = MA_W'(cur_u); mb = MB_W'(cur_u); end
            3'd1:    begin ma = MA_W'(cur_w); mb = MB_W'(cur_w); end
            3'd2:    begin ma = ww_reg;       mb = MB_W'(cur_w); end
            3'd3:    begin ma = ww_reg;       mb = MB_W'(cur_u) * MB_W'(3); end
            3'd4:    begin ma = uu_reg;       mb = MB_W'(cur_w) * MB_W'(3); end
            default: begin ma = uu_reg;       mb = MB_W'(cur_u); end
        endcase
        mprod = (MA_W+MB_W)'(ma) * (MA_W+MB_W)'(mb);
    end

    // Final rounding and saturation of each lane.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            fin[l] = (col_acc_reg[l] + COL_W'(32768)) >>> 16;
            if (fin[l] > COL_W'(32'sh7FFFFFFF))
                sat[l] = 32'sh7FFFFFFF;
            else if (fin[l] < -COL_W'(64'sh80000000))
                sat[l] = 32'sh80000000;
            else
                sat[l] = COORD_W'(fin[l]);
        end
    end

    // Sequencer: divide, weights, then six vertices of multiply-accumulate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_valid   <= 1'b0;
            div_cnt_reg <= '0;
            wp_reg      <= '0;
            ws_reg      <= '0;
            vk_reg      <= '0;
            ri_reg      <= '0;
            cj_reg      <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && head_item.command == CMD_EMIT)
                    begin
                        level_reg <= head_item.level;
                        dvd_reg[0] <= {head_item.cell_u, 16'd0};
                        dvd_reg[1] <= {head_item.cell_u + LEVEL_W'(1), 16'd0};
                        dvd_reg[2] <= {head_item.cell_v, 16'd0};
                        dvd_reg[3] <= {head_item.cell_v + LEVEL_W'(1), 16'd0};
                        for (int p = 0; p < 4; p++)
                        begin
                            rem_reg[p] <= '0;
                            quo_reg[p] <= '0;
                        end
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    for (int p = 0; p < 4; p++)
                    begin
                        if ({rem_reg[p][LEVEL_W-1:0], dvd_reg[p][DIVIDEND_W-1]}
                            >= {1'b0, level_reg})
                        begin
                            rem_reg[p] <= {rem_reg[p][LEVEL_W-1:0],
                                           dvd_reg[p][DIVIDEND_W-1]} - {1'b0, level_reg};
                            quo_reg[p] <= {quo_reg[p][DIVIDEND_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[p] <= {rem_reg[p][LEVEL_W-1:0],
                                           dvd_reg[p][DIVIDEND_W-1]};
                            quo_reg[p] <= {quo_reg[p][DIVIDEND_W-2:0], 1'b0};
                        end
                        dvd_reg[p] <= {dvd_reg[p][DIVIDEND_W-2:0], 1'b0};
                    end
                    if (div_cnt_reg == 5'(DIVIDEND_W - 1))
                    begin
                        wp_reg    <= '0;
                        ws_reg    <= '0;
                        state_reg <= S_WGT;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                    end
                end
                S_WGT:
                begin
                    case (ws_reg)
                        3'd0:    uu_reg <= mprod[MA_W-1:0];
                        3'd1:    ww_reg <= mprod[MA_W-1:0];
                        3'd2:    wgt_reg[wp_reg][0] <= mprod[32 +: PARAM_W];
                        3'd3:    wgt_reg[wp_reg][1] <= mprod[32 +: PARAM_W];
                        3'd4:    wgt_reg[wp_reg][2] <= mprod[32 +: PARAM_W];
                        default: wgt_reg[wp_reg][3] <= mprod[32 +: PARAM_W];
                    endcase
                    if (ws_reg == 3'd5)
                    begin
                        ws_reg <= '0;
                        if (wp_reg == 2'd3)
                        begin
                            vk_reg <= '0;
                            ri_reg <= '0;
                            cj_reg <= '0;
                            for (int l = 0; l < 3; l++)
                            begin
                                row_acc_reg[l] <= '0;
                                col_acc_reg[l] <= '0;
                            end
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            wp_reg <= wp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ws_reg <= ws_reg + 3'd1;
                    end
                end
                S_RD:
                begin
                    if (cj_reg[2])
                    begin
                        w_reg <= wgt_reg[{1'b0, du}][ri_reg];
                        for (int l = 0; l < 3; l++)
                            rnd_reg[l] <= OPND_W'((row_acc_reg[l] + ROW_W'(32768)) >>> 16);
                    end
                    else
                    begin
                        w_reg <= wgt_reg[{1'b1, dv}][cj_reg[1:0]];
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        if (cj_reg[2])
                            prod_reg[l] <= rnd_reg[l] * $signed({1'b0, w_reg});
                        else
                            prod_reg[l] <= OPND_W'(p_reg[l]) * $signed({1'b0, w_reg});
                    end
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (cj_reg[2])
                    begin
                        for (int l = 0; l < 3; l++)
                        begin
                            col_acc_reg[l] <= col_acc_reg[l] + COL_W'(prod_reg[l]);
                            row_acc_reg[l] <= '0;
                        end
                        cj_reg <= '0;
                        if (ri_reg == 2'd3)
                            state_reg <= S_OUT;
                        else
                        begin
                            ri_reg    <= ri_reg + 2'd1;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        for (int l = 0; l < 3; l++)
                            row_acc_reg[l] <= row_acc_reg[l] + ROW_W'(prod_reg[l]);
                        cj_reg    <= cj_reg + 3'd1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid   <= 1'b1;
                        vert_x      <= sat[0];
                        vert_y      <= sat[1];
                        vert_z      <= sat[2];
                        vert_index  <= vk_reg;
                        last_vertex <= (vk_reg == 3'd5);
                        ri_reg      <= '0;
                        cj_reg      <= '0;
                        for (int l = 0; l < 3; l++)
                        begin
                            row_acc_reg[l] <= '0;
                            col_acc_reg[l] <= '0;
                        end
                        if (vk_reg == 3'd5)
                            state_reg <= S_IDLE;
                        else
                        begin
                            vk_reg    <= vk_reg + 3'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/bicubic_bezier_patch_tessellator_top.sv @@
// Load word: pushed into the queue, then written to the point store when it is popped.
// Emit word: from pop to the sixth vertex the back runs the grid divide, then the
// Bernstein weights on one shared multiplier, then each vertex in the three
// multiply-accumulate lanes; it pops no new word until the sixth vertex is out.
// Reset clears control state and sets the level to 4; the point store is not cleared.
module bicubic_bezier_patch_tessellator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bbpt_pkg::LEVEL_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [bbpt_pkg::SLOT_W-1:0]      point_slot,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_x,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_y,
    input  logic signed [bbpt_pkg::COORD_W-1:0] point_z,
    input  logic [bbpt_pkg::CELL_W-1:0]      cell_u,
    input  logic [bbpt_pkg::CELL_W-1:0]      cell_v,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_x,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_y,
    output logic signed [bbpt_pkg::COORD_W-1:0] vert_z,
    output logic [2:0]                       vert_index,
    output logic                             last_vertex
);
    import bbpt_pkg::*;

    logic        push;
    logic        pop;
    bbpt_item_t  push_item;
    bbpt_item_t  head_item;
    bbpt_qstat_t qstat;

    // Front: level register, clamping and queue push.
    bbpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .point_slot (point_slot),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cell_u     (cell_u),
        .cell_v     (cell_v),
        .qstat      (qstat),
        .push       (push),
        .push_item  (push_item)
    );

    // Queue between the two halves.
    bbpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // Back: point store and surface evaluation.
    bbpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vert_x      (vert_x),
        .vert_y      (vert_y),
        .vert_z      (vert_z),
        .vert_index  (vert_index),
        .last_vertex (last_vertex)
    );

endmodule
